// ----- hw/rtl/sequence_inversion_monitor_defines.svh -----
// Assertion macros for the sequence inversion monitor
`ifndef SEQUENCE_INVERSION_MONITOR_DEFINES_SVH
`define SEQUENCE_INVERSION_MONITOR_DEFINES_SVH
`ifndef SYNTHESIS
// check a property every clock edge outside reset
`define SIM_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("sim assertion failed");
// check an implication every clock edge outside reset
`define SIM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sim implication failed");
`else
`define SIM_ASSERT(label, clk, rst, prop)
`define SIM_ASSERT_IMP(label, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/sim_pkg.sv -----
// Package: types and constants of the sequence inversion monitor
`default_nettype none
package sim_pkg;
  localparam int WINDOW  = 1024;
  localparam int ID_BITS = 24;
  localparam int POS_W   = 32;
  localparam int MAXD_W  = 33;
  localparam int SPAN_W  = 10;
  localparam int SLOT_W  = $clog2(WINDOW);
  localparam int CNT_W   = SLOT_W + 1;

  localparam logic [SPAN_W-1:0] SPAN_RESET = SPAN_W'(512);
  localparam logic [MAXD_W-1:0] MAXD_NONE  = {MAXD_W{1'b1}};

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_READ,
    S_CHECK,
    S_DONE
  } sim_state_t;

  typedef struct packed {
    logic               valid;
    logic [ID_BITS-1:0] id;
    logic [POS_W-1:0]   pos;
  } sim_entry_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [SLOT_W-1:0] addr;
    sim_entry_t        wdata;
  } sim_mem_req_t;

  typedef struct packed {
    logic               inversion;
    logic [ID_BITS-1:0] greater_id;
    logic [POS_W-1:0]   greater_pos;
    logic [POS_W-1:0]   distance;
    logic [MAXD_W-1:0]  max_distance;
    logic               out_of_window;
  } sim_res_t;
endpackage
`default_nettype wire

// ----- hw/rtl/sim_ifs.sv -----
// Interfaces: trigger word, result word and configuration channels
`default_nettype none
interface sim_trig_if;
  logic                        valid;
  logic                        ready;
  logic [sim_pkg::ID_BITS-1:0] trigger_id;
  logic [sim_pkg::POS_W-1:0]   record_pos;
  modport source (output valid, trigger_id, record_pos, input ready);
  modport sink (input valid, trigger_id, record_pos, output ready);
endinterface

interface sim_res_if;
  logic                        valid;
  logic                        ready;
  logic                        inversion;
  logic [sim_pkg::ID_BITS-1:0] greater_id;
  logic [sim_pkg::POS_W-1:0]   greater_pos;
  logic [sim_pkg::POS_W-1:0]   distance;
  logic [sim_pkg::MAXD_W-1:0]  max_distance;
  logic                        out_of_window;
  modport source (output valid, inversion, greater_id, greater_pos, distance,
                  max_distance, out_of_window, input ready);
  modport sink (input valid, inversion, greater_id, greater_pos, distance,
                max_distance, out_of_window, output ready);
endinterface

interface sim_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [sim_pkg::SPAN_W-1:0] window_span;
  modport source (output valid, window_span, input ready);
  modport sink (input valid, window_span, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/sim_table_mem.sv -----
// Slot table memory: one read/write port, registered read data
`default_nettype none
module sim_table_mem (
  input  wire                    clk,
  input  sim_pkg::sim_mem_req_t  req,
  output sim_pkg::sim_entry_t    rdata
);
  import sim_pkg::*;

  sim_entry_t mem [WINDOW];

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rdata <= mem[req.addr];
      end
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/sim_ctrl.sv -----
// Sequencer: insert, greater-key search, eviction and running maximum
`default_nettype none
`include "sequence_inversion_monitor_defines.svh"
module sim_ctrl (
  input  wire                        clk,
  input  wire                        rst,
  sim_trig_if.sink                   trig_ch,
  input  wire [sim_pkg::SPAN_W-1:0]  span,
  input  wire                        res_free,
  output logic                       res_load,
  output sim_pkg::sim_res_t          res,
  output sim_pkg::sim_mem_req_t      mem_req,
  input  sim_pkg::sim_entry_t        mem_rdata
);
  import sim_pkg::*;

  sim_state_t         state, state_next;
  logic [SLOT_W-1:0]  clr_cnt, clr_cnt_next;
  logic [ID_BITS-1:0] cur_id, cur_id_next;
  logic [POS_W-1:0]   cur_pos, cur_pos_next;
  logic               oow, oow_next;
  logic               found, found_next;
  logic [ID_BITS-1:0] gid, gid_next;
  logic [POS_W-1:0]   gpos, gpos_next;
  logic [POS_W-1:0]   gdist, gdist_next;
  logic [ID_BITS-1:0] k, k_next;
  logic               evict_mode, evict_mode_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [ID_BITS-1:0] lo, lo_next, hi, hi_next;
  logic [MAXD_W-1:0]  largest, largest_next;

  logic               hit, fits, ins, present, evict_hit;
  logic [ID_BITS-1:0] lo_m, hi_m, lo_e, hi_e;
  logic [CNT_W-1:0]   cnt_e;
  logic [MAXD_W-1:0]  max_upd;

  assign hit     = mem_rdata.valid && (mem_rdata.id == cur_id);
  assign lo_m    = (cur_id < lo) ? cur_id : lo;
  assign hi_m    = (cur_id > hi) ? cur_id : hi;
  assign fits    = (cnt == '0) || ((hi_m - lo_m) < ID_BITS'(WINDOW));
  assign ins     = !hit && fits;
  assign lo_e    = ins ? ((cnt == '0) ? cur_id : lo_m) : lo;
  assign hi_e    = ins ? ((cnt == '0) ? cur_id : hi_m) : hi;
  assign cnt_e   = ins ? cnt + CNT_W'(1) : cnt;
  assign present = mem_rdata.valid && (mem_rdata.id == k);
  assign evict_hit = ({1'b0, k} + (ID_BITS+1)'(span)) < {1'b0, cur_id};
  assign max_upd = (largest[MAXD_W-1] || (gdist > largest[POS_W-1:0])) ?
                   {1'b0, gdist} : largest;

  // next state and register updates
  always_comb begin
    state_next      = state;
    clr_cnt_next    = clr_cnt;
    cur_id_next     = cur_id;
    cur_pos_next    = cur_pos;
    oow_next        = oow;
    found_next      = found;
    gid_next        = gid;
    gpos_next       = gpos;
    gdist_next      = gdist;
    k_next          = k;
    evict_mode_next = evict_mode;
    cnt_next        = cnt;
    lo_next         = lo;
    hi_next         = hi;
    largest_next    = largest;
    case (state)
      S_CLEAR: begin
        clr_cnt_next = clr_cnt + SLOT_W'(1);
        if (clr_cnt == {SLOT_W{1'b1}}) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (trig_ch.valid) begin
          cur_id_next  = trig_ch.trigger_id;
          cur_pos_next = trig_ch.record_pos;
          oow_next     = 1'b0;
          found_next   = 1'b0;
          gid_next     = '0;
          gpos_next    = '0;
          gdist_next   = '0;
          state_next   = S_LOOK;
        end
      end
      S_LOOK: begin
        oow_next = !hit && !fits;
        cnt_next = cnt_e;
        lo_next  = lo_e;
        hi_next  = hi_e;
        if (cnt_e != '0 && cur_id < hi_e) begin
          evict_mode_next = 1'b0;
          k_next     = (cur_id < lo_e) ? lo_e : cur_id + ID_BITS'(1);
          state_next = S_READ;
        end else if (cnt_e != '0) begin
          evict_mode_next = 1'b1;
          k_next     = lo_e;
          state_next = S_READ;
        end else begin
          state_next = S_DONE;
        end
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!evict_mode) begin
          if (present) begin
            found_next = 1'b1;
            gid_next   = k;
            gpos_next  = mem_rdata.pos;
            gdist_next = cur_pos - mem_rdata.pos;
            state_next = S_DONE;
          end else begin
            k_next     = k + ID_BITS'(1);
            state_next = S_READ;
          end
        end else if (present && !evict_hit) begin
          lo_next    = k;
          state_next = S_DONE;
        end else begin
          if (present) begin
            cnt_next = cnt - CNT_W'(1);
          end
          if ((present && cnt == CNT_W'(1)) || k == hi) begin
            if (present && cnt == CNT_W'(1)) begin
              lo_next = '0;
              hi_next = '0;
            end
            state_next = S_DONE;
          end else begin
            k_next     = k + ID_BITS'(1);
            state_next = S_READ;
          end
        end
      end
      S_DONE: begin
        if (res_free) begin
          if (found) begin
            largest_next = max_upd;
          end
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // memory requests, handshake and result
  always_comb begin
    mem_req       = '0;
    trig_ch.ready = 1'b0;
    res_load      = 1'b0;
    res.inversion     = found;
    res.greater_id    = gid;
    res.greater_pos   = gpos;
    res.distance      = gdist;
    res.max_distance  = found ? max_upd : largest;
    res.out_of_window = oow;
    case (state)
      S_CLEAR: begin
        mem_req.en   = 1'b1;
        mem_req.we   = 1'b1;
        mem_req.addr = clr_cnt;
      end
      S_IDLE: begin
        trig_ch.ready = 1'b1;
        mem_req.en    = trig_ch.valid;
        mem_req.addr  = trig_ch.trigger_id[SLOT_W-1:0];
      end
      S_LOOK: begin
        mem_req.en    = ins;
        mem_req.we    = 1'b1;
        mem_req.addr  = cur_id[SLOT_W-1:0];
        mem_req.wdata = '{valid: 1'b1, id: cur_id, pos: cur_pos};
      end
      S_READ: begin
        mem_req.en   = 1'b1;
        mem_req.addr = k[SLOT_W-1:0];
      end
      S_CHECK: begin
        // evicted slot: drop the valid bit
        mem_req.en   = evict_mode && present && evict_hit;
        mem_req.we   = 1'b1;
        mem_req.addr = k[SLOT_W-1:0];
      end
      S_DONE: begin
        res_load = res_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      cnt     <= '0;
      lo      <= '0;
      hi      <= '0;
      largest <= MAXD_NONE;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
      cnt     <= cnt_next;
      lo      <= lo_next;
      hi      <= hi_next;
      largest <= largest_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_id     <= cur_id_next;
    cur_pos    <= cur_pos_next;
    oow        <= oow_next;
    found      <= found_next;
    gid        <= gid_next;
    gpos       <= gpos_next;
    gdist      <= gdist_next;
    k          <= k_next;
    evict_mode <= evict_mode_next;
  end

  `SIM_ASSERT(a_cnt_bound, clk, rst, cnt <= CNT_W'(WINDOW))
  `SIM_ASSERT_IMP(a_range, clk, rst, cnt != '0, (hi - lo) < ID_BITS'(WINDOW))
  `SIM_ASSERT_IMP(a_load_free, clk, rst, res_load, res_free && state == S_DONE)
  `SIM_ASSERT_IMP(a_look_after_accept, clk, rst, state == S_LOOK,
                  $past(state) == S_IDLE && $past(trig_ch.valid))
endmodule
`default_nettype wire

// ----- hw/rtl/sequence_inversion_monitor.sv -----
// Steps from accepted word to valid result word: insert check, one slot read and check,
// result load; every further slot visited by the greater-key search or eviction walk
// adds one more slot read and check.
// One item in work at a time: the next word is taken in the cycle after the result loads.
// Reset: a clearing pass runs through all WINDOW (1024) slots of the table memory;
// no trigger word is taken until it ends. Span resets to 512, maximum distance to -1.
`default_nettype none
module sequence_inversion_monitor (
  input  wire        clk,
  input  wire        rst,
  sim_trig_if.sink   trig_ch,
  sim_cfg_if.sink    cfg_ch,
  sim_res_if.source  res_ch
);
  import sim_pkg::*;

  logic [SPAN_W-1:0] span;
  logic              res_free;
  logic              res_load;
  sim_res_t          res_next;
  sim_res_t          res_q;
  logic              res_valid;
  sim_mem_req_t      mem_req;
  sim_entry_t        mem_rdata;

  // config: always ready; must be written only while idle (not enforced)
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      span <= SPAN_RESET;
    end else if (cfg_ch.valid) begin
      span <= cfg_ch.window_span;
    end
  end

  sim_table_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  sim_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .trig_ch   (trig_ch),
    .span      (span),
    .res_free  (res_free),
    .res_load  (res_load),
    .res       (res_next),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  // output register: frees the sequencer while a result word waits
  assign res_free = !res_valid || res_ch.ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_ch.ready) begin
      res_valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_q <= res_next;
    end
  end

  assign res_ch.valid         = res_valid;
  assign res_ch.inversion     = res_q.inversion;
  assign res_ch.greater_id    = res_q.greater_id;
  assign res_ch.greater_pos   = res_q.greater_pos;
  assign res_ch.distance      = res_q.distance;
  assign res_ch.max_distance  = res_q.max_distance;
  assign res_ch.out_of_window = res_q.out_of_window;
endmodule
`default_nettype wire

// ----- verif/tb_sequence_inversion_monitor.sv -----
// Testbench for sequence_inversion_monitor: random and directed trigger words, checked by scoreboard
`timescale 1ns / 100ps
`default_nettype none

// Shadow of the first-position table; predicts each result word and matches it.
class inversion_scoreboard;
  bit                             slot_used [sim_pkg::WINDOW];
  logic [sim_pkg::ID_BITS-1:0]    slot_id   [sim_pkg::WINDOW];
  logic [sim_pkg::POS_W-1:0]      slot_pos  [sim_pkg::WINDOW];
  logic [sim_pkg::ID_BITS-1:0]    low_key;
  logic [sim_pkg::ID_BITS-1:0]    high_key;
  int                             key_count;
  bit                             dist_seen;
  logic [sim_pkg::POS_W-1:0]      dist_peak;
  logic [sim_pkg::SPAN_W-1:0]     span;
  sim_pkg::sim_res_t              pending_results[$];
  int                             mismatches;

  function void clear();
    foreach (slot_used[i]) slot_used[i] = 0;
    low_key = '0;
    high_key = '0;
    key_count = 0;
    dist_seen = 0;
    dist_peak = '0;
    span = sim_pkg::SPAN_RESET;
    pending_results.delete();
    mismatches = 0;
  endfunction

  function void rescan();
    key_count = 0;
    for (int i = 0; i < sim_pkg::WINDOW; i++) begin
      if (slot_used[i]) begin
        if (key_count == 0 || slot_id[i] < low_key) low_key = slot_id[i];
        if (key_count == 0 || slot_id[i] > high_key) high_key = slot_id[i];
        key_count++;
      end
    end
  endfunction

  // accepted trigger word: update shadow table, queue predicted result
  function void note_trigger(logic [sim_pkg::ID_BITS-1:0] id, logic [sim_pkg::POS_W-1:0] pos);
    int                          slot;
    logic [sim_pkg::ID_BITS-1:0] lo, hi;
    sim_pkg::sim_res_t           r;
    slot = id % sim_pkg::WINDOW;
    r = '0;
    if (!(slot_used[slot] && slot_id[slot] == id)) begin
      lo = (key_count != 0 && low_key < id) ? low_key : id;
      hi = (key_count != 0 && high_key > id) ? high_key : id;
      if (key_count == 0 || (hi - lo) < sim_pkg::WINDOW) begin
        slot_used[slot] = 1;
        slot_id[slot] = id;
        slot_pos[slot] = pos;
        rescan();
      end else begin
        r.out_of_window = 1'b1;
      end
    end
    for (int i = 0; i < sim_pkg::WINDOW; i++) begin
      if (slot_used[i] && slot_id[i] > id && (!r.inversion || slot_id[i] < r.greater_id)) begin
        r.inversion = 1'b1;
        r.greater_id = slot_id[i];
        r.greater_pos = slot_pos[i];
      end
    end
    if (r.inversion) begin
      r.distance = pos - r.greater_pos;
      if (!dist_seen || r.distance > dist_peak) dist_peak = r.distance;
      dist_seen = 1;
    end else begin
      for (int i = 0; i < sim_pkg::WINDOW; i++)
        if (slot_used[i] && ({8'b0, slot_id[i]} + span) < {8'b0, id}) slot_used[i] = 0;
      rescan();
    end
    r.max_distance = dist_seen ? {1'b0, dist_peak} : sim_pkg::MAXD_NONE;
    pending_results.push_back(r);
  endfunction

  function void check_result(sim_pkg::sim_res_t got);
    sim_pkg::sim_res_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: result word with none expected: %p", got);
      return;
    end
    want = pending_results.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: result mismatch\n  expected %p\n  actual   %p", want, got);
    end
  endfunction
endclass

module tb_sequence_inversion_monitor;
  localparam longint CYCLE_LIMIT = 40_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  longint cycle_count = 0;
  bit steady = 0;  // when set, neither side idles

  sim_trig_if trig_ch ();
  sim_cfg_if  cfg_ch ();
  sim_res_if  res_ch ();

  inversion_scoreboard sb;

  // running stimulus state: cluster center and record position
  logic [sim_pkg::ID_BITS-1:0] id_center;
  logic [sim_pkg::POS_W-1:0]   pos_now;

  sequence_inversion_monitor u_dut (
    .clk     (clk),
    .rst     (rst),
    .trig_ch (trig_ch),
    .cfg_ch  (cfg_ch),
    .res_ch  (res_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    trig_ch.valid = 1'b0;
    trig_ch.trigger_id = '0;
    trig_ch.record_pos = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.window_span = '0;
    res_ch.ready = 1'b0;
  end

  // result side back-pressure: ~11% idle cycles unless in a steady stretch
  always @(posedge clk) begin
    res_ch.ready <= steady || ($urandom_range(99) >= 11);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // monitors: sample handshakes on the edge, before flops update
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.span = cfg_ch.window_span;
      if (res_ch.valid && res_ch.ready)
        sb.check_result('{res_ch.inversion, res_ch.greater_id, res_ch.greater_pos,
                          res_ch.distance, res_ch.max_distance, res_ch.out_of_window});
      if (trig_ch.valid && trig_ch.ready) sb.note_trigger(trig_ch.trigger_id, trig_ch.record_pos);
    end
  end

  // one trigger word; an optional idle gap first, so valid stays high back to back otherwise
  task automatic send_trigger(input logic [sim_pkg::ID_BITS-1:0] id,
                              input logic [sim_pkg::POS_W-1:0] pos);
    if (!steady && $urandom_range(99) < 11) begin
      trig_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    trig_ch.valid <= 1'b1;
    trig_ch.trigger_id <= id;
    trig_ch.record_pos <= pos;
    do @(posedge clk); while (!trig_ch.ready);
  endtask

  // span write only once the block has drained; it waits on the clock first so the
  // monitor has noted the last accepted word
  task automatic write_span(input logic [sim_pkg::SPAN_W-1:0] value);
    trig_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.window_span <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // random words: mostly a drifting cluster of IDs so the table fills and
  // inversions occur; some repeats, jumps, far IDs and out-of-order positions
  task automatic random_words(input int count);
    logic [sim_pkg::ID_BITS-1:0] id;
    logic [sim_pkg::ID_BITS-1:0] last_id;
    int pick;
    last_id = id_center;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 65) id = 24'(id_center + $urandom_range(600) - 300);
      else if (pick < 78) id = last_id;
      else if (pick < 86) begin
        id_center = 24'(id_center + $urandom_range(500, 3000));
        id = id_center;
      end else if (pick < 92) id = 24'($urandom);
      else id = 24'(id_center + $urandom_range(900, 2000));
      id_center = 24'(id_center + $urandom_range(8));
      if ($urandom_range(99) < 3) pos_now = $urandom;
      else pos_now = pos_now + $urandom_range(50);
      send_trigger(id, pos_now);
      last_id = id;
    end
  endtask

  initial begin
    sb = new;
    sb.clear();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, repeats, wrap of distance, range limit, eviction
    send_trigger(24'd0, 32'd0);
    send_trigger(24'hFFFFFF, 32'hFFFF_FFFF);  // range exceeded against ID 0
    send_trigger(24'd5, 32'd10);
    send_trigger(24'd3, 32'd20);              // inversion against 5
    send_trigger(24'd3, 32'd25);              // repeated ID keeps first position
    send_trigger(24'd4, 32'd5);               // distance wraps
    send_trigger(24'd1023, 32'd30);
    send_trigger(24'd1024, 32'd31);           // maps to slot 0; key range stays within WINDOW
    send_trigger(24'd2, 32'hFFFF_FFF0);
    send_trigger(24'd1023, 32'd40);           // repeated ID, inversion against 1024
    send_trigger(24'd2000, 32'd50);           // out of range, not inserted; evicts keys 2, 1023 and 1024
    send_trigger(24'd1600, 32'd60);
    send_trigger(24'd1700, 32'd70);
    send_trigger(24'd1650, 32'd80);
    write_span(10'd0);                        // zero span evicts all lower keys
    send_trigger(24'd1650, 32'd90);
    send_trigger(24'd1800, 32'd95);
    send_trigger(24'd1799, 32'd96);
    send_trigger(24'hFFFFFE, 32'hFFFF_FFFF);
    send_trigger(24'hFFFFFF, 32'h0000_0000);

    id_center = 24'h00_1000;
    pos_now = 32'hFFFF_0000;
    write_span(10'd1);
    random_words(250);
    write_span(10'd1023);
    steady = 1;                               // long stretch with no idling
    random_words(250);
    steady = 0;
    write_span(10'd512);
    random_words(200);
    for (int p = 0; p < 6; p++) begin
      write_span(10'($urandom_range(1, 1023)));
      random_words(100);
    end
    trig_ch.valid <= 1'b0;

    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/sim_pkg.sv
hw/rtl/sim_ifs.sv
hw/rtl/sim_table_mem.sv
hw/rtl/sim_ctrl.sv
hw/rtl/sequence_inversion_monitor.sv
verif/tb_sequence_inversion_monitor.sv
